// ===== sv/pts_pkg.sv =====
// ----------------------------------------------------------------------------
// pts_pkg
// Shared types and constants of the priority task scheduler.
// ----------------------------------------------------------------------------
package pts_pkg;

  localparam int TASK_SLOTS = 8;
  localparam int SLOT_W     = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;

  typedef enum logic [1:0] {
    SLOT_DEAD    = 2'd0,
    SLOT_READY   = 2'd1,
    SLOT_RUNNING = 2'd2,
    SLOT_BLOCKED = 2'd3
  } slot_state_e;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_SCHED = 1'b1;

  typedef struct packed {
    logic [31:0]       now;
    logic [SLOT_W-1:0] cur;
  } bcast_t;

  typedef struct packed {
    logic              valid;
    logic [SLOT_W-1:0] slot;
    slot_state_e       state;
    logic [7:0]        prio;
    logic [31:0]       wake;
  } wr_t;

  typedef struct packed {
    logic              valid;
    logic [SLOT_W-1:0] slot;
    logic              bump;
  } commit_t;

  typedef struct packed {
    logic              valid;
    logic              picked;
    logic [7:0]        best;
    logic [SLOT_W-1:0] pick;
    logic [31:0]       pick_runs;
    logic              cur_live;
  } tok_t;

endpackage

// ===== sv/pts_cell.sv =====
// ----------------------------------------------------------------------------
// pts_cell
// One task slot: holds its state, priority, wake tick and run count and
// refines the selection token on its way down the chain.
// ----------------------------------------------------------------------------
module pts_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [pts_pkg::SLOT_W-1:0] idx_i,
  input  pts_pkg::bcast_t           bcast_i,
  input  pts_pkg::wr_t              wr_i,
  input  pts_pkg::commit_t          commit_i,
  input  pts_pkg::tok_t             tok_i,
  output pts_pkg::tok_t             tok_o
);
  import pts_pkg::*;

  slot_state_e state_q, state_d;
  logic [7:0]  prio_q, prio_d;
  logic [31:0] wake_q, wake_d;
  logic [31:0] runs_q, runs_d;
  tok_t        tok_q, tok_d;

  slot_state_e st_eff, st_new;
  logic        is_cur, live;

  always_comb begin
    is_cur = (idx_i == bcast_i.cur);
    st_eff = (is_cur && state_q == SLOT_RUNNING) ? SLOT_READY : state_q;
    st_new = st_eff;
    if (st_eff == SLOT_BLOCKED && bcast_i.now >= wake_q) begin
      st_new = SLOT_READY;
    end
    live = (st_new == SLOT_READY) || (st_new == SLOT_RUNNING);

    tok_d = tok_i;
    if (tok_i.valid) begin
      if (live) begin
        if (prio_q > tok_i.best) begin
          tok_d.best      = prio_q;
          tok_d.pick      = idx_i;
          tok_d.picked    = 1'b1;
          tok_d.pick_runs = runs_q;
        end else if (prio_q == tok_i.best && tok_i.picked &&
                     idx_i > bcast_i.cur && tok_i.pick <= bcast_i.cur) begin
          tok_d.pick      = idx_i;
          tok_d.pick_runs = runs_q;
        end
      end
      if (is_cur) begin
        tok_d.cur_live = live;
      end
    end

    state_d = state_q;
    prio_d  = prio_q;
    wake_d  = wake_q;
    runs_d  = runs_q;
    priority if (wr_i.valid && wr_i.slot == idx_i) begin
      state_d = wr_i.state;
      prio_d  = wr_i.prio;
      wake_d  = wr_i.wake;
    end else if (commit_i.valid && commit_i.slot == idx_i) begin
      state_d = SLOT_RUNNING;
      if (commit_i.bump) begin
        runs_d = runs_q + 32'd1;
      end
    end else if (tok_i.valid) begin
      state_d = st_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SLOT_DEAD;
      prio_q  <= '0;
      wake_q  <= '0;
      runs_q  <= '0;
      tok_q   <= '0;
    end else begin
      state_q <= state_d;
      prio_q  <= prio_d;
      wake_q  <= wake_d;
      runs_q  <= runs_d;
      tok_q   <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

// ===== sv/priority_task_scheduler_core.sv =====
// ----------------------------------------------------------------------------
// priority_task_scheduler_core
// Priority task scheduler with round-robin tie-break over a chain of slots.
// ----------------------------------------------------------------------------
// Input stream (s_axis): tuser = action (0 write slot, 1 schedule).
//   A write transaction loads one task slot; its result is registered and
//   leaves in the cycle after acceptance. A schedule transaction sends a
//   selection token down the row of TASK_SLOTS slot cells, one cell per
//   cycle; the result is registered once the token leaves the last cell.
// Output stream (m_axis): one result transaction per input transaction.
// Throughput: one item at a time; a write every cycle while the receiver
//   takes results, and no new input during a schedule's token walk.
// The input is accepted while the scheduler is idle and the output register
//   is empty or being drained, so a stalled receiver holds the input off
//   after one pending result.
// Reset: all slots dead with zero priority, wake tick and run count; the
//   current slot and the switch counter are zero.
// ----------------------------------------------------------------------------
module priority_task_scheduler_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [2:0] slot_index, [4:3] slot_state, [12:5] slot_priority,
  // [44:13] wake_tick, [76:45] now_tick, [79:77] zero
  input  logic [79:0] s_axis_tdata,
  // [0] action
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [2:0] chosen_task, [3] switched, [35:4] total_switches,
  // [67:36] chosen_runs, [71:68] zero
  output logic [71:0] m_axis_tdata
);
  import pts_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_WALK = 1'b1;

  logic              state_q, state_d;
  logic [SLOT_W-1:0] cur_q, cur_d;
  logic [31:0]       total_q, total_d;
  logic [31:0]       cur_runs_q, cur_runs_d;
  logic [31:0]       now_q, now_d;
  tok_t              start_q, start_d;
  logic              out_valid_q, out_valid_d;
  logic [71:0]       out_data_q, out_data_d;

  tok_t              tok [0:TASK_SLOTS];
  bcast_t            bcast;
  wr_t               wr;
  commit_t           commit;

  logic              accept, done;
  logic [2:0]        in_slot;
  logic [SLOT_W-1:0] pick;
  logic [31:0]       pick_runs;
  logic              same;

  assign in_slot       = s_axis_tdata[2:0];
  assign s_axis_tready = (state_q == ST_IDLE) && (!out_valid_q || m_axis_tready);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign done          = (state_q == ST_WALK) && tok[TASK_SLOTS].valid;

  assign bcast.now = now_q;
  assign bcast.cur = cur_q;

  assign wr.valid = accept && (s_axis_tuser == ACT_WRITE) &&
                    (32'(in_slot) < TASK_SLOTS);
  assign wr.slot  = SLOT_W'(in_slot);
  assign wr.state = slot_state_e'(s_axis_tdata[4:3]);
  assign wr.prio  = s_axis_tdata[12:5];
  assign wr.wake  = s_axis_tdata[44:13];

  assign tok[0] = start_q;

  for (genvar g = 0; g < TASK_SLOTS; g++) begin : g_cell
    pts_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .idx_i    (SLOT_W'(g)),
      .bcast_i  (bcast),
      .wr_i     (wr),
      .commit_i (commit),
      .tok_i    (tok[g]),
      .tok_o    (tok[g+1])
    );
  end

  always_comb begin
    pick      = tok[TASK_SLOTS].picked ? tok[TASK_SLOTS].pick : cur_q;
    pick_runs = tok[TASK_SLOTS].picked ? tok[TASK_SLOTS].pick_runs : cur_runs_q;
    same      = (pick == cur_q) && tok[TASK_SLOTS].cur_live;

    commit.valid = done;
    commit.slot  = same ? cur_q : pick;
    commit.bump  = !same;

    state_d     = state_q;
    cur_d       = cur_q;
    total_d     = total_q;
    cur_runs_d  = cur_runs_q;
    now_d       = now_q;
    start_d     = '0;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_data_d  = out_data_q;

    if (accept) begin
      if (s_axis_tuser == ACT_SCHED) begin
        state_d       = ST_WALK;
        now_d         = s_axis_tdata[76:45];
        start_d.valid = 1'b1;
      end else begin
        out_valid_d = 1'b1;
        out_data_d  = {4'd0, cur_runs_q, total_q, 1'b0, 3'(cur_q)};
      end
    end

    if (done) begin
      state_d     = ST_IDLE;
      out_valid_d = 1'b1;
      if (same) begin
        out_data_d = {4'd0, cur_runs_q, total_q, 1'b0, 3'(cur_q)};
      end else begin
        cur_d      = pick;
        total_d    = total_q + 32'd1;
        cur_runs_d = pick_runs + 32'd1;
        out_data_d = {4'd0, pick_runs + 32'd1, total_q + 32'd1, 1'b1, 3'(pick)};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cur_q       <= '0;
      total_q     <= '0;
      cur_runs_q  <= '0;
      start_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cur_q       <= cur_d;
      total_q     <= total_d;
      cur_runs_q  <= cur_runs_d;
      start_q     <= start_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    now_q      <= now_d;
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule
